### hdl/pm_pkg.sv
`default_nettype none

package pm_pkg;

	// Default sizes of the coefficient stores and of one input coefficient
	localparam int MAX_TERMS_DEF   = 16;
	localparam int COEFF_WIDTH_DEF = 16;

	// Fixed widths of the result fields
	localparam int ACC_W       = 36;
	localparam int POWER_W     = 5;
	localparam int OUT_TDATA_W = ((ACC_W + 7) / 8) * 8;

	// Polynomial selector carried on the input tuser
	localparam logic MODE_FIRST  = 1'b0;
	localparam logic MODE_SECOND = 1'b1;

endpackage

`default_nettype wire

### hdl/polynomial_multiplier.sv
`default_nettype none

// Polynomial multiplier. Coefficients of two signed polynomials stream in on
// the slave side, lowest power first; tuser picks the polynomial (0 = first,
// 1 = second) and tlast on a second-polynomial request closes the job. Each
// request is taken while the block is idle; coefficients past MAX_TERMS
// are dropped, and tlast on the first polynomial does nothing. On the
// closing request the block computes product coefficients 0 to la+lb-2
// one after another with a single shared multiplier and accumulator, each
// term a[i]*b[k-i] passing through three steps (store read, multiply,
// accumulate). Each product coefficient waits in the output register until
// taken; no new request is accepted until the last product coefficient
// (master tlast) has been taken. An empty first polynomial yields a single
// zero coefficient at power 0. Sums wrap modulo 2^36; the power field
// carries the low five bits of the exponent.
module polynomial_multiplier #(
	parameter int MAX_TERMS   = pm_pkg::MAX_TERMS_DEF,
	parameter int COEFF_WIDTH = pm_pkg::COEFF_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// slave side: coefficient requests
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((COEFF_WIDTH+7)/8)*8-1:0]      s_tdata,  // [COEFF_WIDTH-1:0] coeff
	input  wire logic                                  s_tuser,  // [0] mode
	input  wire logic                                  s_tlast,  // last coefficient of polynomial
	// master side: product coefficients
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [pm_pkg::OUT_TDATA_W-1:0]             m_tdata,  // [35:0] product_coeff
	output logic [pm_pkg::POWER_W-1:0]                 m_tuser,  // [4:0] power
	output logic                                       m_tlast   // highest coefficient of run
);

	localparam int AW = $clog2(MAX_TERMS);        // store address
	localparam int CW = $clog2(MAX_TERMS + 1);    // coefficient count
	localparam int SW = $clog2(2 * MAX_TERMS + 1); // power index and count sums
	localparam int PW = 2 * COEFF_WIDTH;          // raw product

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADDR = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_ACC  = 2'd3;

	logic [1:0]                 state_q;
	logic                       out_q;       // result waiting in the output register
	logic [CW-1:0]              la_q;
	logic [CW-1:0]              lb_q;
	logic [SW-1:0]              k_q;         // current product power
	logic [AW-1:0]              i_q;         // current first-polynomial index
	logic                       empty_q;
	logic [pm_pkg::ACC_W-1:0]   acc_q;
	logic signed [PW-1:0]       prod_q;

	logic                       req_ok;
	logic                       mode;
	logic [COEFF_WIDTH-1:0]     coeff;
	logic                       we_a;
	logic                       we_b;
	logic [CW-1:0]              lb_next;
	logic                       start;
	logic [AW-1:0]              b_addr;
	logic [COEFF_WIDTH-1:0]     a_rd;
	logic [COEFF_WIDTH-1:0]     b_rd;
	logic [SW-1:0]              la_m1;
	logic [SW-1:0]              i_hi;
	logic                       i_done;
	logic [SW-1:0]              k_inc;
	logic [AW-1:0]              i_lo_next;
	logic                       is_last;
	logic                       res_take;

	// Accept requests only while no job is running
	assign s_tready = (state_q == S_IDLE) && !out_q;
	assign req_ok   = s_tvalid && s_tready;
	assign mode     = s_tuser;
	assign coeff    = s_tdata[COEFF_WIDTH-1:0];

	assign we_a    = req_ok && (mode == pm_pkg::MODE_FIRST) && (la_q < CW'(MAX_TERMS));
	assign we_b    = req_ok && (mode == pm_pkg::MODE_SECOND) && (lb_q < CW'(MAX_TERMS));
	assign lb_next = we_b ? lb_q + CW'(1) : lb_q;
	assign start   = req_ok && (mode == pm_pkg::MODE_SECOND) && s_tlast;

	// Term window for power k: i runs from max(0, k-lb+1) to min(k, la-1)
	assign la_m1     = SW'(la_q) - SW'(1);
	assign i_hi      = (k_q < la_m1) ? k_q : la_m1;
	assign i_done    = (SW'(i_q) == i_hi);
	assign b_addr    = AW'(k_q - SW'(i_q));
	assign k_inc     = k_q + SW'(1);
	assign i_lo_next = (k_inc >= SW'(lb_q)) ? AW'(k_inc - SW'(lb_q) + SW'(1)) : '0;

	// Top power is la+lb-2
	assign is_last  = empty_q || ((k_q + SW'(2)) == (SW'(la_q) + SW'(lb_q)));
	assign res_take = out_q && m_tready;

	pm_ram #(
		.WIDTH(COEFF_WIDTH),
		.DEPTH(MAX_TERMS)
	) u_first_ram (
		.clk   (clk),
		.we    (we_a),
		.waddr (la_q[AW-1:0]),
		.wdata (coeff),
		.raddr (i_q),
		.rdata (a_rd)
	);

	pm_ram #(
		.WIDTH(COEFF_WIDTH),
		.DEPTH(MAX_TERMS)
	) u_second_ram (
		.clk   (clk),
		.we    (we_b),
		.waddr (lb_q[AW-1:0]),
		.wdata (coeff),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	// Shared multiplier: one term product per pass
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= $signed(a_rd) * $signed(b_rd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_q   <= 1'b0;
			la_q    <= '0;
			lb_q    <= '0;
			k_q     <= '0;
			i_q     <= '0;
			empty_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (out_q) begin
				// Hold the result until taken, then advance or close the run
				if (res_take) begin
					out_q <= 1'b0;
					acc_q <= '0;
					if (is_last) begin
						la_q    <= '0;
						lb_q    <= '0;
						k_q     <= '0;
						empty_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_inc;
						i_q     <= i_lo_next;
						state_q <= S_ADDR;
					end
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (we_a) begin
							la_q <= la_q + CW'(1);
						end
						if (req_ok && (mode == pm_pkg::MODE_SECOND)) begin
							lb_q <= lb_next;
						end
						if (start) begin
							k_q   <= '0;
							i_q   <= '0;
							acc_q <= '0;
							if ((la_q == '0) || (lb_next == '0)) begin
								empty_q <= 1'b1;
								out_q   <= 1'b1;
							end else begin
								state_q <= S_ADDR;
							end
						end
					end
					S_ADDR: begin
						state_q <= S_MUL;
					end
					S_MUL: begin
						state_q <= S_ACC;
					end
					S_ACC: begin
						acc_q <= acc_q + pm_pkg::ACC_W'(prod_q);
						if (i_done) begin
							out_q   <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_ADDR;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_q;
	assign m_tdata  = pm_pkg::OUT_TDATA_W'(acc_q);
	assign m_tuser  = pm_pkg::POWER_W'(k_q);
	assign m_tlast  = is_last;

	// Never take a request while a result is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request accepted while result pending");

	// The term index stays inside the stored first polynomial while working
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR) |-> (SW'(i_q) <= i_hi) && (la_q != '0))
		else $error("term index out of range");

	// Closing the run empties both stores
	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (la_q == '0) && (lb_q == '0) && s_tready)
		else $error("stores not cleared after run");

	// A run starts at power zero with a clear accumulator
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == pm_pkg::MODE_SECOND) && s_tlast)
		|=> (k_q == '0) && (acc_q == '0))
		else $error("run did not start at power zero");

endmodule

`default_nettype wire

### hdl/pm_ram.sv
`default_nettype none

module pm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### verif/polynomial_multiplier_tb.sv
`default_nettype none

module polynomial_multiplier_tb;

	localparam int MAX_TERMS = pm_pkg::MAX_TERMS_DEF;
	localparam int COEFF_W   = pm_pkg::COEFF_WIDTH_DEF;
	localparam int S_TDATA_W = ((COEFF_W + 7) / 8) * 8;

	// One coefficient request as it goes onto the slave side
	typedef struct packed {
		logic               mode;
		logic [COEFF_W-1:0] value;
		logic               fin;
	} coeff_req_t;

	// One product coefficient as it should leave the master side
	typedef struct packed {
		logic [pm_pkg::ACC_W-1:0]   coeff;
		logic [pm_pkg::POWER_W-1:0] power;
		logic                       fin;
	} product_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [S_TDATA_W-1:0]           s_tdata  = '0;   // [15:0] coeff
	logic                           s_tuser  = 1'b0; // [0] mode
	logic                           s_tlast  = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [pm_pkg::OUT_TDATA_W-1:0] m_tdata;         // [35:0] product_coeff
	logic [pm_pkg::POWER_W-1:0]     m_tuser;         // [4:0] power
	logic                           m_tlast;

	// Requests waiting to be driven, and products waiting to be seen
	coeff_req_t coeff_q[$];
	product_t   product_q[$];

	// Shadow copy of the two coefficient stores
	logic signed [COEFF_W-1:0] first_terms[MAX_TERMS];
	logic signed [COEFF_W-1:0] second_terms[MAX_TERMS];
	int first_cnt  = 0;
	int second_cnt = 0;

	int n_items    = 0;
	int n_accepted = 0;
	int n_errors   = 0;
	bit in_fire    = 1'b0;
	bit hold_rx    = 1'b0;
	bit tx_calm    = 1'b0;
	bit rx_calm    = 1'b0;
	int tx_wait    = 0;
	int rx_wait    = 0;

	polynomial_multiplier u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Print one line per mismatch and count it
	task automatic flag_error(input string msg);
		n_errors++;
		$display("[mismatch] %s", msg);
	endtask

	// Store one accepted coefficient; on the closing request of the second
	// polynomial, work out the whole product and clear both stores.
	task automatic take_coeff(input logic mode, input logic [COEFF_W-1:0] raw, input logic fin);
		product_t                 p;
		logic [pm_pkg::ACC_W-1:0] acc;
		longint                   term;
		int                       total;
		if (mode == pm_pkg::MODE_FIRST) begin
			// tlast on the first polynomial does nothing; extra terms drop
			if (first_cnt < MAX_TERMS) begin
				first_terms[first_cnt] = raw;
				first_cnt++;
			end
			return;
		end
		if (second_cnt < MAX_TERMS) begin
			second_terms[second_cnt] = raw;
			second_cnt++;
		end
		if (!fin)
			return;
		if (first_cnt == 0 || second_cnt == 0) begin
			// Empty first polynomial: a single zero at power 0
			p.coeff = '0;
			p.power = '0;
			p.fin   = 1'b1;
			product_q.push_back(p);
		end else begin
			total = first_cnt + second_cnt - 1;
			for (int k = 0; k < total; k++) begin
				acc = '0;
				for (int i = 0; i < first_cnt; i++) begin
					if (k >= i && k - i < second_cnt) begin
						term = longint'(first_terms[i]) * longint'(second_terms[k - i]);
						acc  = acc + term[pm_pkg::ACC_W-1:0];
					end
				end
				p.coeff = acc;
				p.power = k[pm_pkg::POWER_W-1:0];
				p.fin   = (k == total - 1);
				product_q.push_back(p);
			end
		end
		first_cnt  = 0;
		second_cnt = 0;
	endtask

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [COEFF_W-1:0] pick_coeff();
		logic [COEFF_W-1:0] v;
		int                 r;
		r = $urandom_range(0, 99);
		if (r < 10)
			v = {1'b1, {(COEFF_W-1){1'b0}}};
		else if (r < 20)
			v = {1'b0, {(COEFF_W-1){1'b1}}};
		else if (r < 35) begin
			v = COEFF_W'($urandom_range(0, 16));
			v = v - COEFF_W'(8);
		end else
			v = COEFF_W'($urandom());
		return v;
	endfunction

	// Polynomial length: mostly small, a few near or past a full store
	function automatic int pick_len(input bit may_be_empty);
		int r;
		r = $urandom_range(0, 99);
		if (may_be_empty && r < 10)
			return 0;
		if (r < 82)
			return $urandom_range(1, 5);
		if (r < 93)
			return $urandom_range(6, 12);
		return $urandom_range(MAX_TERMS - 1, MAX_TERMS + 2);
	endfunction

	task automatic push_coeff(input logic mode, input logic [COEFF_W-1:0] v, input logic fin);
		coeff_req_t c;
		c.mode  = mode;
		c.value = v;
		c.fin   = fin;
		coeff_q.push_back(c);
	endtask

	// Queue one job: na first-polynomial terms and nb second-polynomial terms,
	// sometimes interleaved, closed by tlast on the last second term.
	task automatic add_job(input int na, input int nb);
		int fa;
		int fb;
		bit mix;
		fa  = na;
		fb  = nb - 1;
		mix = ($urandom_range(0, 3) == 0);
		while (fa > 0 || fb > 0) begin
			if (fb == 0 || (fa > 0 && (!mix || $urandom_range(0, 1) == 0))) begin
				push_coeff(pm_pkg::MODE_FIRST, pick_coeff(), $urandom_range(0, 4) == 0);
				fa--;
			end else begin
				push_coeff(pm_pkg::MODE_SECOND, pick_coeff(), 1'b0);
				fb--;
			end
		end
		push_coeff(pm_pkg::MODE_SECOND, pick_coeff(), 1'b1);
	endtask

	// Sample both handshakes at the rising edge; predict on every accepted
	// request and check every accepted product against the oldest one due.
	always @(posedge clk) begin
		product_t want;
		in_fire = s_tvalid && s_tready;
		if (in_fire) begin
			take_coeff(s_tuser, s_tdata[COEFF_W-1:0], s_tlast);
			n_accepted++;
		end
		if (m_tvalid && m_tready) begin
			if (product_q.size() == 0)
				flag_error($sformatf("unexpected product power=%0d coeff=%h",
					m_tuser, m_tdata[pm_pkg::ACC_W-1:0]));
			else begin
				want = product_q.pop_front();
				if (m_tdata[pm_pkg::ACC_W-1:0] !== want.coeff)
					flag_error($sformatf("power %0d: coeff %h, want %h",
						want.power, m_tdata[pm_pkg::ACC_W-1:0], want.coeff));
				if (m_tuser !== want.power)
					flag_error($sformatf("power %0d, want %0d", m_tuser, want.power));
				if (m_tlast !== want.fin)
					flag_error($sformatf("power %0d: tlast %b, want %b",
						want.power, m_tlast, want.fin));
			end
		end
	end

	// Sender: advance to the next request once the current one is taken,
	// with random gaps between requests.
	always @(negedge clk) begin
		coeff_req_t cur;
		if ($urandom_range(0, 249) == 0)
			tx_calm = !tx_calm;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (tx_wait > 0) begin
				s_tvalid <= 1'b0;
				tx_wait--;
			end else if (coeff_q.size() > 0) begin
				cur = coeff_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= S_TDATA_W'(cur.value);
				s_tuser  <= cur.mode;
				s_tlast  <= cur.fin;
				tx_wait  = idle_len(tx_calm);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Receiver: drop tready for random stretches, and for the long hold-off
	always @(negedge clk) begin
		if ($urandom_range(0, 249) == 0)
			rx_calm = !rx_calm;
		if (!arst_n || hold_rx)
			m_tready <= 1'b0;
		else if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
			rx_wait  = idle_len(rx_calm);
		end
	end

	// Hold off the receiver for a long stretch in mid-run so the block backs
	// up and stalls the sender.
	initial begin
		while (n_accepted < 60)
			@(posedge clk);
		hold_rx = 1'b1;
		repeat (500)
			@(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin
		#3000000;
		$display("[polynomial_multiplier] ERROR");
		$finish;
	end

	initial begin
		int n_directed;
		// Empty first polynomial: one zero coefficient
		push_coeff(pm_pkg::MODE_SECOND, 16'h7fff, 1'b1);
		// Extreme values; tlast on the first polynomial must not close it
		push_coeff(pm_pkg::MODE_FIRST, 16'h8000, 1'b1);
		push_coeff(pm_pkg::MODE_FIRST, 16'h7fff, 1'b0);
		push_coeff(pm_pkg::MODE_SECOND, 16'h8000, 1'b0);
		push_coeff(pm_pkg::MODE_SECOND, 16'h7fff, 1'b0);
		push_coeff(pm_pkg::MODE_SECOND, 16'h8000, 1'b1);
		// Overfill the first store; the extra term drops
		for (int i = 0; i < MAX_TERMS + 1; i++)
			push_coeff(pm_pkg::MODE_FIRST, (i % 2) ? 16'h8000 : 16'h7fff, i == 7);
		push_coeff(pm_pkg::MODE_SECOND, 16'h8000, 1'b1);
		n_directed = coeff_q.size();

		// Random jobs, mostly small
		while (coeff_q.size() < n_directed + 100)
			add_job(pick_len(1'b1), pick_len(1'b0));
		// Close with two full stores of the most negative value (largest sum)
		add_job(0, 0);
		for (int i = 0; i < MAX_TERMS; i++)
			push_coeff(pm_pkg::MODE_FIRST, 16'h8000, 1'b0);
		for (int i = 0; i < MAX_TERMS; i++)
			push_coeff(pm_pkg::MODE_SECOND, 16'h8000, i == MAX_TERMS - 1);
		n_items = coeff_q.size();

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_items)
			@(posedge clk);
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (100)
			@(posedge clk);
		if (n_errors == 0)
			$display("[polynomial_multiplier] OK");
		else
			$display("[polynomial_multiplier] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
